// ----- rtl/core/drs_pkg.sv -----
package drs_pkg;

  localparam int RingDepthDefault = 1024;
  localparam int TimeW = 40;
  localparam int PnW = 48;
  localparam int SizeW = 16;
  localparam int InflW = 32;
  localparam int BwW = 31;
  localparam int CntW = 16;
  localparam logic [PnW:0] MaxLead = 49'd10000;
  localparam logic [PnW-1:0] BwMax = 48'h0000_7fff_ffff;
  localparam logic [TimeW-1:0] ZeroGapDiv = 40'd5;
  localparam logic [CntW-1:0] CntMax = 16'hffff;

  typedef enum logic [2:0] {
    KIND_SENT  = 3'd0,
    KIND_ACKED = 3'd1,
    KIND_LOST  = 3'd2,
    KIND_APPL  = 3'd3,
    KIND_RMOLD = 3'd4,
    KIND_QUERY = 3'd5
  } kind_e;

  typedef struct packed {
    logic [TimeW-1:0] tx_stamp;
    logic [SizeW-1:0] size;
    logic [PnW-1:0]   acked_snap;
    logic [TimeW-1:0] last_ack;
    logic             times_known;
    logic             app_limited;
    logic             ignored;
  } entry_t;

  localparam entry_t EntryRetired = '{
    tx_stamp: '0, size: '0, acked_snap: '0, last_ack: '0,
    times_known: 1'b0, app_limited: 1'b0, ignored: 1'b1
  };

endpackage

// ----- rtl/core/drs_ram.sv -----
module drs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/drs_div.sv -----
module drs_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [drs_pkg::PnW-1:0]      dividend_i,
  input  logic [drs_pkg::TimeW-1:0]    divisor_i,
  output logic                         done_o,
  output logic [drs_pkg::PnW-1:0]      quotient_o
);

  localparam int QW = drs_pkg::PnW;
  localparam int RW = drs_pkg::TimeW;
  localparam int CW = $clog2(QW);

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [RW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [RW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[QW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = RW'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = trial[RW-1:0];
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/core/delivery_rate_sampler_unit.sv -----
// channel | direction | handshake             | word
// in      | input     | in_valid_i/in_ready_o   | kind, event_time, pkt_num, size, inflight
// out     | output    | out_valid_o/out_ready_i | sample fields and status
// Sent, lost, app_limited and unused kinds pass EXEC then OUT; a query or ack in the window also reads in READ.
// An ack with a sample then waits in DIVW for the bit-serial divider.
// remove_old retires one ring entry per cycle in its sweep state.
// After reset a clearing pass writes every ring entry as retired before in_ready_o rises.
// A stalled output holds the block in its output state; one word waits there.
module delivery_rate_sampler_unit #(
  parameter int RING_DEPTH = drs_pkg::RingDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   kind_i,
  input  logic [drs_pkg::TimeW-1:0]    event_time_i,
  input  logic [drs_pkg::PnW-1:0]      pkt_num_i,
  input  logic [drs_pkg::SizeW-1:0]    data_size_i,
  input  logic [drs_pkg::InflW-1:0]    bytes_in_flight_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         sample_valid_o,
  output logic [drs_pkg::BwW-1:0]      bandwidth_o,
  output logic [drs_pkg::TimeW-1:0]    rtt_o,
  output logic                         sample_app_limited_o,
  output logic [drs_pkg::PnW-1:0]      total_acked_o,
  output logic                         app_limited_now_o,
  output logic [drs_pkg::PnW-1:0]      last_sent_number_o,
  output logic [drs_pkg::CntW-1:0]     tracked_count_o,
  output logic [drs_pkg::SizeW-1:0]    queried_size_o
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int PW = drs_pkg::PnW;
  localparam int TW = drs_pkg::TimeW;
  localparam logic [AW:0] DepthW = (AW+1)'(RING_DEPTH);

  typedef enum logic [6:0] {
    ST_CLR   = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_EXEC  = 7'b0000100,
    ST_READ  = 7'b0001000,
    ST_DIVW  = 7'b0010000,
    ST_SWEEP = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [2:0]                  kind_q;
  logic [TW-1:0]               time_q;
  logic [PW-1:0]               pn_q;
  logic [drs_pkg::SizeW-1:0]   size_q;
  logic                        inzero_q;

  logic [PW-1:0] tot_q, tot_d, nsent_q, nsent_d, aend_q, aend_d;
  logic [PW-1:0] oldest_q, oldest_d, newest_q, newest_d;
  logic [TW-1:0] lack_q, lack_d;
  logic          lknown_q, lknown_d, aflag_q, aflag_d, any_q, any_d;
  logic [drs_pkg::CntW-1:0] live_q, live_d;
  logic [AW-1:0] base_q, base_d, clr_q, clr_d, slot_q, slot_d;

  logic                       smp_v_q, smp_v_d, smp_a_q, smp_a_d;
  logic [TW-1:0]              rtt_q, rtt_d;
  logic [drs_pkg::BwW-1:0]    bw_q, bw_d;
  logic [drs_pkg::SizeW-1:0]  qs_q, qs_d;

  logic                              ov_q, ov_d, o_sv_q, o_sa_q, o_al_q;
  logic [drs_pkg::BwW-1:0]           o_bw_q;
  logic [TW-1:0]                     o_rtt_q;
  logic [PW-1:0]                     o_tot_q, o_ls_q;
  logic [drs_pkg::CntW-1:0]          o_cnt_q;
  logic [drs_pkg::SizeW-1:0]         o_qs_q;
  logic                              o_load;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  drs_pkg::entry_t ram_wdata, rd;
  logic [$bits(drs_pkg::entry_t)-1:0] rd_raw;

  logic          div_start, div_done;
  logic [PW-1:0] div_dvd, div_q;
  logic [TW-1:0] div_dvs;

  logic          accept, in_win;
  logic [PW-1:0] old_eff, diff, tot_new;
  logic [AW:0]   ssum;
  logic [AW-1:0] slot;
  logic [AW-1:0] base_inc;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_win = any_q && (pn_q >= oldest_q) && (pn_q <= newest_q);
  assign old_eff = any_q ? oldest_q : pn_q;
  assign diff = pn_q - old_eff;
  assign ssum = {1'b0, base_q} + {1'b0, diff[AW-1:0]};
  assign slot = (ssum >= DepthW) ? AW'(ssum - DepthW) : ssum[AW-1:0];
  assign base_inc = ({1'b0, base_q} + 1'b1 >= DepthW) ? '0 : AW'(base_q + 1'b1);
  assign rd = drs_pkg::entry_t'(rd_raw);
  assign tot_new = tot_q + PW'(rd.size);

  always_comb begin
    state_d  = state_q;
    tot_d    = tot_q;
    nsent_d  = nsent_q;
    aend_d   = aend_q;
    oldest_d = oldest_q;
    newest_d = newest_q;
    lack_d   = lack_q;
    lknown_d = lknown_q;
    aflag_d  = aflag_q;
    any_d    = any_q;
    live_d   = live_q;
    base_d   = base_q;
    clr_d    = clr_q;
    slot_d   = slot_q;
    smp_v_d  = smp_v_q;
    smp_a_d  = smp_a_q;
    rtt_d    = rtt_q;
    bw_d     = bw_q;
    qs_d     = qs_q;
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = drs_pkg::EntryRetired;
    ram_re    = 1'b0;
    ram_raddr = slot;
    div_start = 1'b0;
    div_dvd   = tot_new - rd.acked_snap;
    div_dvs   = drs_pkg::ZeroGapDiv;
    o_load    = 1'b0;
    ov_d      = ov_q && !out_ready_i;

    unique case (state_q)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = AW'(clr_q + 1'b1);
        if (clr_q == AW'(RING_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        smp_v_d = 1'b0;
        smp_a_d = 1'b0;
        rtt_d   = '0;
        bw_d    = '0;
        qs_d    = '0;
        slot_d  = slot;
        state_d = ST_OUT;
        case (kind_q)
          drs_pkg::KIND_SENT: begin
            nsent_d = pn_q;
            if (inzero_q) begin
              lack_d   = time_q;
              lknown_d = 1'b1;
            end
            if (!(any_q && ({1'b0, newest_q} + drs_pkg::MaxLead < {1'b0, pn_q})) &&
                !(any_q && (pn_q <= oldest_q)) && (diff < PW'(RING_DEPTH))) begin
              any_d    = 1'b1;
              oldest_d = old_eff;
              newest_d = pn_q;
              ram_we   = 1'b1;
              ram_wdata.tx_stamp    = time_q;
              ram_wdata.size        = size_q;
              ram_wdata.acked_snap  = tot_q;
              ram_wdata.last_ack    = inzero_q ? time_q : lack_q;
              ram_wdata.times_known = inzero_q || lknown_q;
              ram_wdata.app_limited = aflag_q;
              ram_wdata.ignored     = 1'b0;
              if (live_q != drs_pkg::CntMax) begin
                live_d = live_q + 1'b1;
              end
            end else if (!any_q) begin
              any_d    = 1'b1;
              oldest_d = pn_q;
            end
          end
          drs_pkg::KIND_ACKED, drs_pkg::KIND_QUERY: begin
            if (in_win) begin
              ram_re  = 1'b1;
              state_d = ST_READ;
            end
          end
          drs_pkg::KIND_LOST: begin
            if (in_win) begin
              ram_we = 1'b1;
              if (pn_q == oldest_q && newest_q > oldest_q) begin
                oldest_d = oldest_q + 1'b1;
                base_d   = base_inc;
              end
              if (live_q != '0) begin
                live_d = live_q - 1'b1;
              end
            end
          end
          drs_pkg::KIND_APPL: begin
            aflag_d = 1'b1;
            aend_d  = nsent_q;
          end
          drs_pkg::KIND_RMOLD: begin
            state_d = ST_SWEEP;
          end
          default: begin
          end
        endcase
      end
      ST_READ: begin
        state_d = ST_OUT;
        if (kind_q == drs_pkg::KIND_QUERY) begin
          qs_d = rd.ignored ? '0 : rd.size;
        end else if (!rd.ignored) begin
          tot_d    = tot_new;
          lack_d   = time_q;
          lknown_d = 1'b1;
          if (aflag_q && pn_q > aend_q) begin
            aflag_d = 1'b0;
          end
          ram_we    = 1'b1;
          ram_waddr = slot_q;
          if (pn_q == oldest_q && newest_q > oldest_q) begin
            oldest_d = oldest_q + 1'b1;
            base_d   = base_inc;
          end
          if (live_q != '0) begin
            live_d = live_q - 1'b1;
          end
          if (rd.times_known) begin
            if ({1'b0, time_q} > {1'b0, rd.last_ack} + (TW+1)'(drs_pkg::ZeroGapDiv)) begin
              div_dvs   = time_q - rd.last_ack;
              div_start = 1'b1;
              rtt_d     = (time_q > rd.tx_stamp) ? time_q - rd.tx_stamp : '0;
              smp_a_d   = rd.app_limited;
              state_d   = ST_DIVW;
            end else if (time_q == rd.last_ack) begin
              div_start = 1'b1;
              rtt_d     = (time_q > rd.tx_stamp) ? time_q - rd.tx_stamp : '0;
              smp_a_d   = rd.app_limited;
              state_d   = ST_DIVW;
            end
          end
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          smp_v_d = 1'b1;
          bw_d    = (div_q > drs_pkg::BwMax) ? drs_pkg::BwMax[drs_pkg::BwW-1:0]
                                             : div_q[drs_pkg::BwW-1:0];
          state_d = ST_OUT;
        end
      end
      ST_SWEEP: begin
        if (any_q && oldest_q < pn_q && oldest_q < newest_q) begin
          ram_we    = 1'b1;
          ram_waddr = base_q;
          oldest_d  = oldest_q + 1'b1;
          base_d    = base_inc;
          if (live_q != '0) begin
            live_d = live_q - 1'b1;
          end
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_q || out_ready_i) begin
          o_load  = 1'b1;
          ov_d    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      tot_q    <= '0;
      nsent_q  <= '0;
      aend_q   <= '0;
      oldest_q <= '0;
      newest_q <= '0;
      lack_q   <= '0;
      lknown_q <= 1'b0;
      aflag_q  <= 1'b0;
      any_q    <= 1'b0;
      live_q   <= '0;
      base_q   <= '0;
      clr_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      tot_q    <= tot_d;
      nsent_q  <= nsent_d;
      aend_q   <= aend_d;
      oldest_q <= oldest_d;
      newest_q <= newest_d;
      lack_q   <= lack_d;
      lknown_q <= lknown_d;
      aflag_q  <= aflag_d;
      any_q    <= any_d;
      live_q   <= live_d;
      base_q   <= base_d;
      clr_q    <= clr_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_i;
      time_q   <= event_time_i;
      pn_q     <= pkt_num_i;
      size_q   <= data_size_i;
      inzero_q <= (bytes_in_flight_i == '0);
    end
    slot_q  <= slot_d;
    smp_v_q <= smp_v_d;
    smp_a_q <= smp_a_d;
    rtt_q   <= rtt_d;
    bw_q    <= bw_d;
    qs_q    <= qs_d;
    if (o_load) begin
      o_sv_q  <= smp_v_q;
      o_bw_q  <= bw_q;
      o_rtt_q <= rtt_q;
      o_sa_q  <= smp_a_q;
      o_tot_q <= tot_q;
      o_al_q  <= aflag_q;
      o_ls_q  <= nsent_q;
      o_cnt_q <= live_q;
      o_qs_q  <= qs_q;
    end
  end

  drs_ram #(
    .Width($bits(drs_pkg::entry_t)),
    .Depth(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rd_raw)
  );

  drs_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quotient_o(div_q)
  );

  assign out_valid_o          = ov_q;
  assign sample_valid_o       = o_sv_q;
  assign bandwidth_o          = o_bw_q;
  assign rtt_o                = o_rtt_q;
  assign sample_app_limited_o = o_sa_q;
  assign total_acked_o        = o_tot_q;
  assign app_limited_now_o    = o_al_q;
  assign last_sent_number_o   = o_ls_q;
  assign tracked_count_o      = o_cnt_q;
  assign queried_size_o       = o_qs_q;

  a_window_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q |-> (newest_q >= oldest_q) && ((newest_q - oldest_q) < PW'(RING_DEPTH)))
    else $error("tracked window exceeds ring depth");

  a_div_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> state_q == ST_READ)
    else $error("divider started outside read state");

  a_out_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("output word raised outside output state");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLR || state_q == ST_EXEC || state_q == ST_READ ||
                state_q == ST_SWEEP))
    else $error("ring written in a wait state");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int TimeW = drs_pkg::TimeW;
  localparam int PnW = drs_pkg::PnW;
  localparam int SizeW = drs_pkg::SizeW;
  localparam int InflW = drs_pkg::InflW;
  localparam int BwW = drs_pkg::BwW;
  localparam int CntW = drs_pkg::CntW;
  localparam logic [PnW:0] MaxLead = drs_pkg::MaxLead;
  localparam logic [PnW-1:0] BwMax = drs_pkg::BwMax;
  localparam logic [CntW-1:0] CntMax = drs_pkg::CntMax;
  localparam int Depth = drs_pkg::RingDepthDefault;
  localparam longint unsigned CycleLimit = 3_000_000;

  typedef struct {
    logic [2:0]       kind;
    logic [TimeW-1:0] t;
    logic [PnW-1:0]   pn;
    logic [SizeW-1:0] sz;
    logic [InflW-1:0] infl;
  } word_t;

  typedef struct {
    logic             sv;
    logic [BwW-1:0]   bw;
    logic [TimeW-1:0] rtt;
    logic             sal;
    logic [PnW-1:0]   acked;
    logic             aln;
    logic [PnW-1:0]   last_sent;
    logic [CntW-1:0]  cnt;
    logic [SizeW-1:0] qsz;
  } status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] kind_i = '0;
  logic [TimeW-1:0] event_time_i = '0;
  logic [PnW-1:0] pkt_num_i = '0;
  logic [SizeW-1:0] data_size_i = '0;
  logic [InflW-1:0] bytes_in_flight_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic sample_valid_o;
  logic [BwW-1:0] bandwidth_o;
  logic [TimeW-1:0] rtt_o;
  logic sample_app_limited_o;
  logic [PnW-1:0] total_acked_o;
  logic app_limited_now_o;
  logic [PnW-1:0] last_sent_number_o;
  logic [CntW-1:0] tracked_count_o;
  logic [SizeW-1:0] queried_size_o;

  delivery_rate_sampler_unit u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [TimeW-1:0] rec_time [Depth];
  logic [SizeW-1:0] rec_size [Depth];
  logic [PnW-1:0]   rec_acked [Depth];
  logic [TimeW-1:0] rec_last_ack [Depth];
  logic             rec_known [Depth];
  logic             rec_appl [Depth];
  logic             rec_retired [Depth];
  logic [PnW-1:0]   sent_total, acked_total;
  logic [TimeW-1:0] last_ack_ms;
  logic             ack_known, appl_flag, have_window;
  logic [PnW-1:0]   newest_sent, appl_end, win_lo, win_hi;
  logic [CntW-1:0]  live;

  word_t   pending_words[$];
  status_t expected_status[$];
  int      errors = 0;
  bit      hold_out = 0;
  longint unsigned cycles = 0;

  function automatic int slot(logic [PnW-1:0] n);
    return int'(n % Depth);
  endfunction

  function automatic bit in_win(logic [PnW-1:0] n);
    return have_window && n >= win_lo && n <= win_hi;
  endfunction

  task automatic model_clear();
    for (int i = 0; i < Depth; i++) begin
      rec_time[i] = '0; rec_size[i] = '0; rec_acked[i] = '0; rec_last_ack[i] = '0;
      rec_known[i] = 0; rec_appl[i] = 0; rec_retired[i] = 1;
    end
    sent_total = '0; acked_total = '0; last_ack_ms = '0; ack_known = 0;
    newest_sent = '0; appl_flag = 0; appl_end = '0; win_lo = '0;
    have_window = 0; win_hi = '0; live = '0;
  endtask

  task automatic retire_packet(logic [PnW-1:0] n);
    int s;
    if (!in_win(n)) return;
    s = slot(n);
    rec_retired[s] = 1;
    if (n == win_lo) begin
      rec_time[s] = '0; rec_size[s] = '0; rec_acked[s] = '0; rec_last_ack[s] = '0;
      rec_known[s] = 0; rec_appl[s] = 0;
      if (win_hi > win_lo) win_lo++;
    end
    if (live > 0) live--;
  endtask

  task automatic predict_status(word_t w, output status_t r);
    int s;
    logic [PnW-1:0] delta;
    logic [PnW-1:0] rate;
    logic [TimeW-1:0] prev;
    r = '{default: '0};
    case (w.kind)
      drs_pkg::KIND_SENT: begin
        newest_sent = w.pn;
        sent_total = sent_total + w.sz;
        if (w.infl == 0) begin
          last_ack_ms = w.t; ack_known = 1;
        end
        if (!(have_window && ({1'b0, win_hi} + MaxLead) < {1'b0, w.pn}) &&
            !(have_window && w.pn <= win_lo)) begin
          if (!have_window) begin
            win_lo = w.pn; have_window = 1;
          end
          if (w.pn - win_lo < Depth) begin
            win_hi = w.pn;
            s = slot(w.pn);
            rec_time[s] = w.t; rec_size[s] = w.sz; rec_acked[s] = acked_total;
            rec_last_ack[s] = last_ack_ms; rec_known[s] = ack_known;
            rec_appl[s] = appl_flag; rec_retired[s] = 0;
            if (live != CntMax) live++;
          end
        end
      end
      drs_pkg::KIND_ACKED: begin
        s = slot(w.pn);
        if (in_win(w.pn) && !rec_retired[s]) begin
          acked_total = acked_total + rec_size[s];
          last_ack_ms = w.t; ack_known = 1;
          if (appl_flag && w.pn > appl_end) appl_flag = 0;
          if (rec_known[s]) begin
            prev = rec_last_ack[s];
            delta = acked_total - rec_acked[s];
            if ({1'b0, w.t} > {1'b0, prev} + 41'd5) begin
              rate = delta / (w.t - prev); r.sv = 1;
            end else if (w.t == prev) begin
              rate = delta / 5; r.sv = 1;
            end
            if (r.sv) begin
              r.bw = (rate > BwMax) ? BwMax[BwW-1:0] : rate[BwW-1:0];
              r.rtt = (w.t > rec_time[s]) ? w.t - rec_time[s] : '0;
              r.sal = rec_appl[s];
            end
          end
          retire_packet(w.pn);
        end
      end
      drs_pkg::KIND_LOST: retire_packet(w.pn);
      drs_pkg::KIND_APPL: begin
        appl_flag = 1; appl_end = newest_sent;
      end
      drs_pkg::KIND_RMOLD: begin
        while (have_window && win_lo < w.pn && win_lo < win_hi) retire_packet(win_lo);
      end
      drs_pkg::KIND_QUERY: begin
        if (in_win(w.pn) && !rec_retired[slot(w.pn)]) r.qsz = rec_size[slot(w.pn)];
      end
      default: ;
    endcase
    r.acked = acked_total; r.aln = appl_flag; r.last_sent = newest_sent;
    r.cnt = live;
  endtask

  // driver
  int gap = 0;
  always @(posedge clk_i) begin
    word_t w;
    status_t r;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        w = '{kind_i, event_time_i, pkt_num_i, data_size_i, bytes_in_flight_i};
        predict_status(w, r);
        expected_status.push_back(r);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          in_valid_i <= 1'b1;
          kind_i <= w.kind; event_time_i <= w.t; pkt_num_i <= w.pn;
          data_size_i <= w.sz; bytes_in_flight_i <= w.infl;
          gap <= ($urandom_range(0, 2) == 0) ? 0 :
                 ($urandom_range(0, 19) == 0 ? $urandom_range(10, 80) : $urandom_range(0, 3));
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  int hold_left = 0;
  always @(posedge clk_i) begin
    status_t e;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_status.size() == 0) begin
          $display("%0t unexpected word", $time);
          errors++;
        end else begin
          e = expected_status.pop_front();
          if ({sample_valid_o, bandwidth_o, rtt_o, sample_app_limited_o, total_acked_o,
               app_limited_now_o, last_sent_number_o, tracked_count_o, queried_size_o} !==
              {e.sv, e.bw, e.rtt, e.sal, e.acked, e.aln, e.last_sent, e.cnt, e.qsz}) begin
            $display("%0t mismatch exp sv=%0d bw=%0d rtt=%0d sal=%0d acked=%0d al=%0d ls=%0d cnt=%0d q=%0d",
                     $time, e.sv, e.bw, e.rtt, e.sal, e.acked, e.aln, e.last_sent, e.cnt, e.qsz);
            $display("%0t          act sv=%0d bw=%0d rtt=%0d sal=%0d acked=%0d al=%0d ls=%0d cnt=%0d q=%0d",
                     $time, sample_valid_o, bandwidth_o, rtt_o, sample_app_limited_o,
                     total_acked_o, app_limited_now_o, last_sent_number_o, tracked_count_o,
                     queried_size_o);
            errors++;
          end
        end
      end
      if (hold_out) begin
        out_ready_i <= 1'b0;
        hold_left <= 0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        hold_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
    if (cycles > CycleLimit) begin
      $display("** delivery_rate_sampler_unit: FAILED **");
      $finish;
    end
  end

  function automatic word_t mk(logic [2:0] k, logic [TimeW-1:0] t, logic [PnW-1:0] pn,
                               logic [SizeW-1:0] sz, logic [InflW-1:0] infl);
    word_t w;
    w.kind = k; w.t = t; w.pn = pn; w.sz = sz; w.infl = infl;
    return w;
  endfunction

  function automatic logic [InflW-1:0] rnd_infl();
    return ($urandom_range(0, 4) == 0) ? '0 : InflW'($urandom);
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid_i || expected_status.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // a burst of traffic around a base packet number, acks mostly in order
  task automatic flow(logic [PnW-1:0] base, logic [TimeW-1:0] t0, int n);
    logic [TimeW-1:0] t;
    logic [PnW-1:0] hi;
    logic [PnW-1:0] lo;
    int r;
    t = t0; hi = base; lo = base;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 3) != 0) t = t + $urandom_range(0, 12);
      if (r < 40) begin
        hi = hi + (($urandom_range(0, 9) == 0) ? $urandom_range(2, 5) : 1);
        pending_words.push_back(mk(drs_pkg::KIND_SENT, t, hi, SizeW'($urandom), rnd_infl()));
      end else if (r < 70) begin
        if (lo < hi) lo = lo + 1;
        pending_words.push_back(mk(drs_pkg::KIND_ACKED, t, ($urandom_range(0, 5) == 0) ?
                                   hi - $urandom_range(0, 8) : lo, '0, '0));
      end else if (r < 78) pending_words.push_back(mk(drs_pkg::KIND_LOST, t,
                                                      hi - $urandom_range(0, 6), 0, 0));
      else if (r < 84) pending_words.push_back(mk(drs_pkg::KIND_APPL, t, 0, 0, 0));
      else if (r < 88) pending_words.push_back(mk(drs_pkg::KIND_RMOLD, t,
                                                  lo + $urandom_range(0, 3), 0, 0));
      else if (r < 95) pending_words.push_back(mk(drs_pkg::KIND_QUERY, t,
                                                  hi - $urandom_range(0, 10), 0, 0));
      else pending_words.push_back(mk(3'($urandom_range(0, 7)), TimeW'({$urandom, $urandom}),
                                      PnW'({$urandom, $urandom}), SizeW'($urandom), $urandom));
    end
  endtask

  initial begin
    model_clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed
    pending_words.push_back(mk(drs_pkg::KIND_QUERY, 0, 0, 0, 0));
    pending_words.push_back(mk(drs_pkg::KIND_SENT, 100, 10, 16'hffff, 0));
    pending_words.push_back(mk(drs_pkg::KIND_SENT, 100, 11, 1000, 5));
    pending_words.push_back(mk(drs_pkg::KIND_SENT, 101, 12, 0, 32'hffffffff));
    pending_words.push_back(mk(drs_pkg::KIND_SENT, 102, 10, 5, 0));
    pending_words.push_back(mk(drs_pkg::KIND_SENT, 102, 10 + Depth, 5, 7));
    pending_words.push_back(mk(drs_pkg::KIND_SENT, 102, 48'hffffffffffff, 5, 7));
    pending_words.push_back(mk(drs_pkg::KIND_QUERY, 103, 11, 0, 0));
    pending_words.push_back(mk(drs_pkg::KIND_ACKED, 100, 11, 0, 0));
    pending_words.push_back(mk(drs_pkg::KIND_ACKED, 103, 12, 0, 0));
    pending_words.push_back(mk(drs_pkg::KIND_APPL, 103, 0, 0, 0));
    pending_words.push_back(mk(drs_pkg::KIND_SENT, 104, 13, 1500, 0));
    pending_words.push_back(mk(drs_pkg::KIND_SENT, 104, 14, 1500, 9));
    pending_words.push_back(mk(drs_pkg::KIND_ACKED, 40'hffffffffff, 13, 0, 0));
    pending_words.push_back(mk(drs_pkg::KIND_ACKED, 50, 14, 0, 0));
    pending_words.push_back(mk(drs_pkg::KIND_ACKED, 50, 14, 0, 0));
    pending_words.push_back(mk(drs_pkg::KIND_LOST, 50, 99, 0, 0));
    pending_words.push_back(mk(drs_pkg::KIND_LOST, 50, 10, 0, 0));
    pending_words.push_back(mk(6, 1, 1, 1, 1));
    pending_words.push_back(mk(7, 1, 1, 1, 1));
    pending_words.push_back(mk(drs_pkg::KIND_RMOLD, 50, 48'hffffffffffff, 0, 0));
    pending_words.push_back(mk(drs_pkg::KIND_QUERY, 50, 14, 0, 0));
    wait_drained();
    // long receiver stall while sender keeps offering
    hold_out = 1;
    flow(20, 200, 30);
    repeat (600) @(posedge clk_i);
    hold_out = 0;
    wait_drained();
    // random flows, occasionally at far packet numbers and times
    for (int k = 0; k < 14; k++) begin
      flow((k % 4 == 3) ? {$urandom, 16'h0} : 48'd0 + 30 + k * 200,
           (k % 5 == 4) ? {8'hff, $urandom} : 40'd300 + k * 5000, 100);
      if (k % 5 == 2) wait_drained();
    end
    wait_drained();
    if (errors == 0) begin
      $display("** delivery_rate_sampler_unit: PASSED **");
    end else begin
      $display("** delivery_rate_sampler_unit: FAILED **");
    end
    $finish;
  end

endmodule
